FILE: hdl/pcb_pkg.sv
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared types and constants of the performance counter bank.
// ----------------------------------------------------------------------------
package pcb_pkg;

    localparam int LANE_COUNT_DEF   = 4;
    localparam int METRIC_COUNT_DEF = 13;
    localparam int LOG_DEPTH_DEF    = 256;

    typedef enum logic [2:0] {
        MODE_SET        = 3'd0,
        MODE_ADD        = 3'd1,
        MODE_MAX        = 3'd2,
        MODE_TICK_BEGIN = 3'd3,
        MODE_TICK_END   = 3'd4,
        MODE_READ       = 3'd5,
        MODE_CLEAR      = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_FETCH,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [63:0]        last_value;
        logic [63:0]        peak_value;
        logic [63:0]        log_value;
        logic [63:0]        log_tick;
        logic signed [63:0] log_act;
        logic               log_valid;
        logic [8:0]         log_count;
        logic               log_overflow;
    } rsp_t;

endpackage

FILE: hdl/pcb_ifs.sv
// ----------------------------------------------------------------------------
// pcb_ifs
// Request, response and configuration channels of the counter bank.
// ----------------------------------------------------------------------------
interface pcb_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [2:0]         lane;
    logic [3:0]         metric;
    logic [63:0]        value;
    logic signed [63:0] act_time;
    logic [63:0]        tick_number;
    logic [7:0]         sample_index;

    modport source (output valid, mode, lane, metric, value, act_time, tick_number,
                    sample_index, input ready);
    modport sink (input valid, mode, lane, metric, value, act_time, tick_number,
                  sample_index, output ready);
endinterface

interface pcb_rsp_if;
    logic               valid;
    logic               ready;
    logic [63:0]        last_value;
    logic [63:0]        peak_value;
    logic [63:0]        log_value;
    logic [63:0]        log_tick;
    logic signed [63:0] log_act;
    logic               log_valid;
    logic [8:0]         log_count;
    logic               log_overflow;

    modport source (output valid, last_value, peak_value, log_value, log_tick, log_act,
                    log_valid, log_count, log_overflow, input ready);
    modport sink (input valid, last_value, peak_value, log_value, log_tick, log_act,
                  log_valid, log_count, log_overflow, output ready);
endinterface

interface pcb_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hdl/perf_counter_bank_with_snapshots.sv
// ----------------------------------------------------------------------------
// perf_counter_bank_with_snapshots
// Lane-by-metric 64-bit counters with last, peak and a snapshot log.
// ----------------------------------------------------------------------------
// A request other than an enabled tick end is read from the counter
// memories when it is accepted, then updated and written back in the
// update state, at the end of which its result is loaded into the output
// register if that register is free. A tick end that is taken while
// enabled walks every counter through the single read and write port of
// the current, last, peak and log memories, in a read state and a write
// state per counter, then passes through the fetch state to the response
// state, where its result is loaded. The input is held while a request is
// in progress. No clearing pass is needed after reset. The next request is
// accepted while a result still waits in the output register; its own
// result then waits in the block, which takes no further request, until
// the output register frees.
module perf_counter_bank_with_snapshots #(
    parameter int LANE_COUNT   = pcb_pkg::LANE_COUNT_DEF,
    parameter int METRIC_COUNT = pcb_pkg::METRIC_COUNT_DEF,
    parameter int LOG_DEPTH    = pcb_pkg::LOG_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pcb_cfg_if.sink   cfg,
    pcb_req_if.sink   req,
    pcb_rsp_if.source rsp
);

    localparam int CELLS = LANE_COUNT * METRIC_COUNT;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int TA    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int LA    = (LOG_DEPTH * CELLS > 1) ? $clog2(LOG_DEPTH * CELLS) : 1;
    localparam int FW    = $clog2(LOG_DEPTH + 1);

    logic [63:0] cur_mem  [CELLS];
    logic [63:0] last_mem [CELLS];
    logic [63:0] peak_mem [CELLS];
    logic [63:0] log_mem  [LOG_DEPTH * CELLS];
    logic [63:0] tick_mem [LOG_DEPTH];
    logic [63:0] act_mem  [LOG_DEPTH];

    pcb_pkg::state_t    state_reg, state_next;
    logic [2:0]         mode_reg;
    logic [CW-1:0]      cell_reg;
    logic               ok_reg;
    logic [63:0]        value_reg;
    logic [7:0]         sidx_reg;
    logic [63:0]        req_tick_reg;
    logic [63:0]        req_act_reg;
    logic               enabled_reg;
    logic [63:0]        ltick_reg;
    logic [63:0]        lact_reg;
    logic [FW-1:0]      fill_reg;
    logic               ovf_reg;
    logic [CELLS-1:0]   cur_vld_reg;
    logic [CELLS-1:0]   last_vld_reg;
    logic [CELLS-1:0]   peak_vld_reg;
    logic [CW-1:0]      walk_reg;
    logic [63:0]        cur_rd_reg;
    logic [63:0]        last_rd_reg;
    logic [63:0]        peak_rd_reg;
    logic [63:0]        log_rd_reg;
    logic [63:0]        tick_rd_reg;
    logic [63:0]        act_rd_reg;
    pcb_pkg::rsp_t      rsp_reg;
    logic               out_vld_reg;

    logic               in_ok;
    logic [CW-1:0]      in_cell;
    logic [CW-1:0]      rd_cell;
    logic [7:0]         rd_sidx;
    logic [LA-1:0]      rd_log_addr;
    logic [LA-1:0]      wr_log_addr;
    logic               accept;
    logic               can_load;
    logic               load;
    logic               is_clear;
    logic               tick_end_go;
    logic               walk_last;
    logic               log_full;
    logic               cur_we;
    logic [63:0]        cur_old;
    logic [63:0]        cur_new;
    logic [63:0]        walk_cur;
    logic [63:0]        walk_peak;
    logic [63:0]        walk_peak_new;
    logic               log_hit;
    pcb_pkg::rsp_t      rsp_c;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == pcb_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign in_ok   = ({1'b0, req.lane} < 4'(LANE_COUNT))
                     && ({1'b0, req.metric} < 5'(METRIC_COUNT));
    assign in_cell = in_ok ? CW'(8'(req.lane) * 8'(METRIC_COUNT) + 8'(req.metric))
                           : '0;

    always_comb
    begin
        case (state_reg)
            pcb_pkg::ST_IDLE:
            begin
                rd_cell = in_cell;
                rd_sidx = req.sample_index;
            end
            pcb_pkg::ST_WALK_RD:
            begin
                rd_cell = walk_reg;
                rd_sidx = sidx_reg;
            end
            default:
            begin
                rd_cell = cell_reg;
                rd_sidx = sidx_reg;
            end
        endcase
    end

    assign rd_log_addr = LA'(20'(rd_sidx) * 20'(CELLS) + 20'(rd_cell));
    assign wr_log_addr = LA'(20'(fill_reg) * 20'(CELLS) + 20'(walk_reg));
    assign log_full    = (fill_reg == FW'(LOG_DEPTH));
    assign walk_last   = (walk_reg == CW'(CELLS - 1));
    assign is_clear    = (mode_reg == pcb_pkg::MODE_CLEAR);
    assign tick_end_go = enabled_reg && (mode_reg == pcb_pkg::MODE_TICK_END);
    assign can_load    = !out_vld_reg || rsp.ready;

    always_comb
    begin
        cur_old = cur_vld_reg[cell_reg] ? cur_rd_reg : 64'd0;
        case (mode_reg)
            pcb_pkg::MODE_SET: cur_new = value_reg;
            pcb_pkg::MODE_ADD: cur_new = cur_old + value_reg;
            default:           cur_new = (value_reg > cur_old) ? value_reg : cur_old;
        endcase
        walk_cur      = cur_vld_reg[walk_reg] ? cur_rd_reg : 64'd0;
        walk_peak     = peak_vld_reg[walk_reg] ? peak_rd_reg : 64'd0;
        walk_peak_new = (walk_cur > walk_peak) ? walk_cur : walk_peak;
    end

    always_comb
    begin
        log_hit              = (13'(sidx_reg) < 13'(fill_reg));
        rsp_c.last_value     = (ok_reg && last_vld_reg[cell_reg]) ? last_rd_reg : 64'd0;
        rsp_c.peak_value     = (ok_reg && peak_vld_reg[cell_reg]) ? peak_rd_reg : 64'd0;
        rsp_c.log_value      = (ok_reg && log_hit) ? log_rd_reg : 64'd0;
        rsp_c.log_tick       = log_hit ? tick_rd_reg : 64'd0;
        rsp_c.log_act        = log_hit ? act_rd_reg : 64'd0;
        rsp_c.log_valid      = log_hit;
        rsp_c.log_count      = 9'(fill_reg);
        rsp_c.log_overflow   = ovf_reg;
        if (state_reg == pcb_pkg::ST_UPD && is_clear)
        begin
            rsp_c = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pcb_pkg::ST_UPD;
                end
            end
            pcb_pkg::ST_UPD:
            begin
                if (tick_end_go)
                begin
                    state_next = pcb_pkg::ST_WALK_RD;
                end
                else if (can_load)
                begin
                    state_next = pcb_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = pcb_pkg::ST_RESP;
                end
            end
            pcb_pkg::ST_WALK_RD: state_next = pcb_pkg::ST_WALK_WR;
            pcb_pkg::ST_WALK_WR:
            begin
                state_next = walk_last ? pcb_pkg::ST_FETCH : pcb_pkg::ST_WALK_RD;
            end
            pcb_pkg::ST_FETCH: state_next = pcb_pkg::ST_RESP;
            pcb_pkg::ST_RESP:
            begin
                if (can_load)
                begin
                    state_next = pcb_pkg::ST_IDLE;
                end
            end
            default: state_next = pcb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        load   = 1'b0;
        cur_we = 1'b0;
        case (state_reg)
            pcb_pkg::ST_UPD:
            begin
                load   = !tick_end_go && can_load;
                cur_we = enabled_reg && ok_reg && (mode_reg == pcb_pkg::MODE_SET
                         || mode_reg == pcb_pkg::MODE_ADD || mode_reg == pcb_pkg::MODE_MAX);
            end
            pcb_pkg::ST_RESP: load = can_load;
            default:
            begin
                load   = 1'b0;
                cur_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_rd_reg  <= cur_mem[rd_cell];
        last_rd_reg <= last_mem[rd_cell];
        peak_rd_reg <= peak_mem[rd_cell];
        log_rd_reg  <= log_mem[rd_log_addr];
        tick_rd_reg <= tick_mem[TA'(rd_sidx)];
        act_rd_reg  <= act_mem[TA'(rd_sidx)];
        if (cur_we)
        begin
            cur_mem[cell_reg] <= cur_new;
        end
        if (state_reg == pcb_pkg::ST_WALK_WR)
        begin
            last_mem[walk_reg] <= walk_cur;
            peak_mem[walk_reg] <= walk_peak_new;
            if (!log_full)
            begin
                log_mem[wr_log_addr] <= walk_cur;
                if (walk_last)
                begin
                    tick_mem[TA'(fill_reg)] <= ltick_reg;
                    act_mem[TA'(fill_reg)]  <= lact_reg;
                end
            end
        end
        if (accept)
        begin
            mode_reg     <= req.mode;
            cell_reg     <= in_cell;
            ok_reg       <= in_ok;
            value_reg    <= req.value;
            sidx_reg     <= req.sample_index;
            req_tick_reg <= req.tick_number;
            req_act_reg  <= req.act_time;
        end
        if (load)
        begin
            rsp_reg <= rsp_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pcb_pkg::ST_IDLE;
            enabled_reg  <= 1'b0;
            ltick_reg    <= '0;
            lact_reg     <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            cur_vld_reg  <= '0;
            last_vld_reg <= '0;
            peak_vld_reg <= '0;
            walk_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                enabled_reg <= cfg.data;
            end
            if (load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cur_we)
            begin
                cur_vld_reg[cell_reg] <= 1'b1;
            end
            if (state_reg == pcb_pkg::ST_UPD)
            begin
                if (is_clear)
                begin
                    ltick_reg    <= '0;
                    lact_reg     <= '0;
                    fill_reg     <= '0;
                    ovf_reg      <= 1'b0;
                    cur_vld_reg  <= '0;
                    last_vld_reg <= '0;
                    peak_vld_reg <= '0;
                end
                else if (enabled_reg && mode_reg == pcb_pkg::MODE_TICK_BEGIN)
                begin
                    ltick_reg   <= req_tick_reg;
                    lact_reg    <= req_act_reg;
                    cur_vld_reg <= '0;
                end
                walk_reg <= '0;
            end
            if (state_reg == pcb_pkg::ST_WALK_WR)
            begin
                last_vld_reg[walk_reg] <= 1'b1;
                peak_vld_reg[walk_reg] <= 1'b1;
                walk_reg               <= walk_reg + CW'(1);
                if (walk_last)
                begin
                    if (log_full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + FW'(1);
                    end
                end
            end
        end
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.last_value   = rsp_reg.last_value;
    assign rsp.peak_value   = rsp_reg.peak_value;
    assign rsp.log_value    = rsp_reg.log_value;
    assign rsp.log_tick     = rsp_reg.log_tick;
    assign rsp.log_act      = rsp_reg.log_act;
    assign rsp.log_valid    = rsp_reg.log_valid;
    assign rsp.log_count    = rsp_reg.log_count;
    assign rsp.log_overflow = rsp_reg.log_overflow;

endmodule
